@@ rtl/core/afk_pkg.sv @@
// Shared types, constants and tables for the arm forward kinematics core.
// No dependencies; used by afk_cordic and arm_forward_kinematics_core.
package afk_pkg;

  localparam int unsigned ANGLE_WIDTH     = 16;
  localparam int unsigned TRIG_FRAC_BITS  = 15;
  localparam int unsigned REVOLUTE_JOINTS = 5;
  localparam int unsigned CFG_WIDTH       = 16;
  localparam int unsigned CFG_IDX_WIDTH   = 3;
  localparam int unsigned OUT_WIDTH       = 24;
  // Internal position width; every intermediate point stays well inside it.
  localparam int unsigned POS_WIDTH       = 26;

  localparam int unsigned CORDIC_STEPS    = 30;
  localparam int unsigned CORDIC_GAIN     = 652032874;

  // Micro-rotation angles in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_UPPER_ARM = 3'd0,
    CFG_FOREARM   = 3'd1,
    CFG_BASE      = 3'd2,
    CFG_WRIST     = 3'd3,
    CFG_GRIPPER   = 3'd4
  } cfg_idx_e;

  // Twist of a frame: no twist, or a quarter turn either way about x.
  typedef enum logic [1:0] {
    TWIST_NONE = 2'd0,
    TWIST_POS  = 2'd1,
    TWIST_NEG  = 2'd2
  } twist_e;

  localparam twist_e FRAME_TWIST [REVOLUTE_JOINTS] = '{
    TWIST_POS, TWIST_NONE, TWIST_NONE, TWIST_NEG, TWIST_NONE
  };

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] joint_angle_0;
    logic signed [ANGLE_WIDTH-1:0] joint_angle_1;
    logic signed [ANGLE_WIDTH-1:0] joint_angle_2;
    logic signed [ANGLE_WIDTH-1:0] joint_angle_3;
    logic signed [ANGLE_WIDTH-1:0] joint_angle_4;
  } joint_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] pos_x;
    logic signed [OUT_WIDTH-1:0] pos_y;
    logic signed [OUT_WIDTH-1:0] pos_z;
  } pose_out_t;

endpackage

@@ rtl/core/afk_cordic.sv @@
// Pipelined rotation CORDIC: one 32-bit turn in, sine and cosine out.
// Depends on afk_pkg for the arctangent table and gain.
module afk_cordic #(
  parameter int unsigned TRIG_FRAC_BITS = afk_pkg::TRIG_FRAC_BITS,
  localparam int unsigned TrigW = TRIG_FRAC_BITS + 1
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [31:0]             turn_i,
  output logic signed [TrigW-1:0] sin_o,
  output logic signed [TrigW-1:0] cos_o
);

  localparam int unsigned Steps = afk_pkg::CORDIC_STEPS;
  localparam int unsigned CW    = 34;
  localparam int unsigned Shift = 30 - TRIG_FRAC_BITS;
  localparam logic signed [CW-1:0] Rnd    = CW'(1) << (Shift - 1);
  localparam logic signed [CW-1:0] TrigHi = CW'((1 << TRIG_FRAC_BITS) - 1);
  localparam logic signed [CW-1:0] TrigLo = -TrigHi - CW'(1);

  logic signed [CW-1:0] x_q [Steps+1];
  logic signed [CW-1:0] y_q [Steps+1];
  logic signed [CW-1:0] z_q [Steps+1];
  logic                 flip_q [Steps+1];
  logic                 flip_d;
  logic [31:0]          turn_f;

  // Angles in the left half plane are turned by half a turn and negated at the end.
  assign flip_d = turn_i[31] ^ turn_i[30];
  assign turn_f = {turn_i[31] ^ flip_d, turn_i[30:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CW'(afk_pkg::CORDIC_GAIN);
      y_q[0]    <= '0;
      z_q[0]    <= CW'(signed'(turn_f));
      flip_q[0] <= flip_d;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    assign dx = y_q[k] >>> k;
    assign dy = x_q[k] >>> k;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[k][CW-1]) begin
          x_q[k+1] <= x_q[k] - dx;
          y_q[k+1] <= y_q[k] + dy;
          z_q[k+1] <= z_q[k] - CW'(afk_pkg::ATAN_TURN[k]);
        end else begin
          x_q[k+1] <= x_q[k] + dx;
          y_q[k+1] <= y_q[k] - dy;
          z_q[k+1] <= z_q[k] + CW'(afk_pkg::ATAN_TURN[k]);
        end
        flip_q[k+1] <= flip_q[k];
      end
    end
  end

  function automatic logic signed [TrigW-1:0] sat_trig(input logic signed [CW-1:0] v);
    logic signed [TrigW-1:0] r;
    if (v > TrigHi) begin
      r = TrigHi[TrigW-1:0];
    end else if (v < TrigLo) begin
      r = TrigLo[TrigW-1:0];
    end else begin
      r = v[TrigW-1:0];
    end
    return r;
  endfunction

  logic signed [CW-1:0] xr, yr, xn, yn;
  logic signed [TrigW-1:0] sin_q, cos_q;

  assign xr = (x_q[Steps] + Rnd) >>> Shift;
  assign yr = (y_q[Steps] + Rnd) >>> Shift;
  assign xn = flip_q[Steps] ? -xr : xr;
  assign yn = flip_q[Steps] ? -yr : yr;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= sat_trig(xn);
      sin_q <= sat_trig(yn);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

@@ rtl/core/arm_forward_kinematics_core.sv @@
// Arm forward kinematics core: five joint angles in, end-effector position out.
// Depends on afk_pkg and afk_cordic.
//
// The core takes one pose per clock cycle while the output is not stalled and
// returns its position after pipelined CORDIC (angle setup, 30 micro-rotations,
// one rounding stage) run for all five joints side by side and then the five
// frame transforms, each in two stages, one for its four multiplications and
// one for the sums and rounding. A stall on the output holds the whole pipeline,
// so an item can enter again in the cycle the stall is released.
module arm_forward_kinematics_core #(
  parameter int unsigned TRIG_FRAC_BITS = afk_pkg::TRIG_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [afk_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  logic [afk_pkg::CFG_WIDTH-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  afk_pkg::joint_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output afk_pkg::pose_out_t                  out_data_o
);

  localparam int unsigned TrigW   = TRIG_FRAC_BITS + 1;
  localparam int unsigned Joints  = afk_pkg::REVOLUTE_JOINTS;
  localparam int unsigned PosW    = afk_pkg::POS_WIDTH;
  localparam int unsigned ProdW   = PosW + TrigW;
  localparam int unsigned AngW    = afk_pkg::ANGLE_WIDTH;
  localparam int unsigned OutW    = afk_pkg::OUT_WIDTH;
  localparam int unsigned CordLat = afk_pkg::CORDIC_STEPS + 2;
  localparam int unsigned Total   = CordLat + 2 * Joints;
  localparam logic signed [ProdW:0] RndP = (ProdW + 1)'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [PosW-1:0] OutHi = PosW'((1 << (OutW - 1)) - 1);
  localparam logic signed [PosW-1:0] OutLo = -OutHi - PosW'(1);

  // Configuration registers.
  logic [afk_pkg::CFG_WIDTH-1:0] upper_q, forearm_q, base_q, wrist_q, gripper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q   <= 16'd3891;
      forearm_q <= 16'd3891;
      base_q    <= 16'd2662;
      wrist_q   <= 16'd5325;
      gripper_q <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        afk_pkg::CFG_UPPER_ARM: upper_q   <= cfg_wdata_i;
        afk_pkg::CFG_FOREARM:   forearm_q <= cfg_wdata_i;
        afk_pkg::CFG_BASE:      base_q    <= cfg_wdata_i;
        afk_pkg::CFG_WRIST:     wrist_q   <= cfg_wdata_i;
        afk_pkg::CFG_GRIPPER:   gripper_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage advances unless the finished result is held.
  logic             en;
  logic [Total-1:0] vld_q;

  assign en         = !(vld_q[Total-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Total-2:0], in_valid_i};
    end
  end

  // Joint angles as 32-bit turns, with the shoulder and wrist pitch offsets.
  logic [AngW-1:0] ang [Joints];
  logic [31:0]     turn [Joints];

  assign ang[0] = in_data_i.joint_angle_0;
  assign ang[1] = in_data_i.joint_angle_1;
  assign ang[2] = in_data_i.joint_angle_2;
  assign ang[3] = in_data_i.joint_angle_3;
  assign ang[4] = in_data_i.joint_angle_4;

  logic signed [TrigW-1:0] sin_w [Joints];
  logic signed [TrigW-1:0] cos_w [Joints];

  for (genvar i = 0; i < Joints; i++) begin : g_joint
    logic [31:0] base_turn;
    assign base_turn = {ang[i], (32 - AngW)'(0)};
    if (i == 1) begin : g_plus
      assign turn[i] = base_turn + afk_pkg::QUARTER_TURN;
    end else if (i == 3) begin : g_minus
      assign turn[i] = base_turn - afk_pkg::QUARTER_TURN;
    end else begin : g_plain
      assign turn[i] = base_turn;
    end

    afk_cordic #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_cordic (
      .clk_i (clk_i),
      .en_i  (en),
      .turn_i(turn[i]),
      .sin_o (sin_w[i]),
      .cos_o (cos_w[i])
    );
  end

  // Frame chain: the gripper point is carried back through frames 4 down to 0.
  logic signed [PosW-1:0] px [Joints+1];
  logic signed [PosW-1:0] py [Joints+1];
  logic signed [PosW-1:0] pz [Joints+1];

  assign px[0] = '0;
  assign py[0] = '0;
  assign pz[0] = PosW'(gripper_q);

  for (genvar j = 0; j < Joints; j++) begin : g_frame
    localparam int unsigned F = Joints - 1 - j;
    localparam afk_pkg::twist_e Tw = afk_pkg::FRAME_TWIST[F];

    // Trig of this joint, delayed to meet the point at this frame.
    logic signed [TrigW-1:0] s_dl [2*j+1];
    logic signed [TrigW-1:0] c_dl [2*j+1];
    assign s_dl[0] = sin_w[F];
    assign c_dl[0] = cos_w[F];
    for (genvar d = 0; d < 2 * j; d++) begin : g_dly
      always_ff @(posedge clk_i) begin
        if (en) begin
          s_dl[d+1] <= s_dl[d];
          c_dl[d+1] <= c_dl[d];
        end
      end
    end

    logic [afk_pkg::CFG_WIDTH-1:0] len_a, len_d;
    assign len_a = (F == 1) ? upper_q : ((F == 2) ? forearm_q : '0);
    assign len_d = (F == 0) ? base_q : ((F == 4) ? wrist_q : '0);

    logic signed [PosW-1:0] u, w, zn;
    assign u = px[j] + signed'(PosW'(len_a));
    assign w = (Tw == afk_pkg::TWIST_NONE) ? py[j] :
               ((Tw == afk_pkg::TWIST_POS) ? -pz[j] : pz[j]);
    assign zn = ((Tw == afk_pkg::TWIST_NONE) ? pz[j] :
                 ((Tw == afk_pkg::TWIST_POS) ? py[j] : -py[j])) + signed'(PosW'(len_d));

    logic signed [TrigW-1:0] s, c;
    assign s = s_dl[2*j];
    assign c = c_dl[2*j];

    logic signed [ProdW-1:0] cu_q, su_q, cw_q, sw_q;
    logic signed [PosW-1:0]  zn_q;

    always_ff @(posedge clk_i) begin
      if (en) begin
        cu_q <= c * u;
        su_q <= s * u;
        cw_q <= c * w;
        sw_q <= s * w;
        zn_q <= zn;
      end
    end

    logic signed [ProdW:0] nx, ny, nxs, nys;
    assign nx  = (ProdW + 1)'(cu_q) - (ProdW + 1)'(sw_q) + RndP;
    assign ny  = (ProdW + 1)'(su_q) + (ProdW + 1)'(cw_q) + RndP;
    assign nxs = nx >>> TRIG_FRAC_BITS;
    assign nys = ny >>> TRIG_FRAC_BITS;

    always_ff @(posedge clk_i) begin
      if (en) begin
        px[j+1] <= nxs[PosW-1:0];
        py[j+1] <= nys[PosW-1:0];
        pz[j+1] <= zn_q;
      end
    end
  end

  function automatic logic signed [OutW-1:0] sat_out(input logic signed [PosW-1:0] v);
    logic signed [OutW-1:0] r;
    if (v > OutHi) begin
      r = OutHi[OutW-1:0];
    end else if (v < OutLo) begin
      r = OutLo[OutW-1:0];
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

  assign out_valid_o      = vld_q[Total-1];
  assign out_data_o.pos_x = sat_out(px[Joints]);
  assign out_data_o.pos_y = sat_out(py[Joints]);
  assign out_data_o.pos_z = sat_out(pz[Joints]);

  // Magnitudes of the base joint trig, used by the checks below.
  logic [TrigW+1:0] trig_mag;
  assign trig_mag = (TrigW + 2)'(sin_w[0] < 0 ? -sin_w[0] : sin_w[0])
                  + (TrigW + 2)'(cos_w[0] < 0 ? -cos_w[0] : cos_w[0]);

  // A held result freezes every stage of the pipeline.
  a_hold_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline advanced while the result was held");

  // Sine and cosine of a real angle never both collapse toward zero.
  a_trig_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[CordLat-1] |-> (trig_mag >= (TrigW + 2)'((1 << TRIG_FRAC_BITS) - 8)))
    else $error("CORDIC output lost its magnitude");

  // The wrist roll frame sees a point on its axis, so x and y leave it at zero.
  a_roll_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[CordLat+1] |-> (px[1] == '0 && py[1] == '0))
    else $error("wrist roll frame moved a point on its axis");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for arm_forward_kinematics_core: drives joint poses,
// predicts each end-effector position in fixed point and compares in order.
// Depends on afk_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import afk_pkg::*;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 225;
  localparam int unsigned DRAIN_CYCLES  = 60;

  typedef enum logic [1:0] {
    CFG_KEEP = 2'd0,
    CFG_ZERO = 2'd1,
    CFG_MAX  = 2'd2
  } cfg_sel_e;

  typedef struct {
    cfg_sel_e  cfg_sel;
    joint_in_t pose;
    bit        typed;
    pose_out_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i = '0;
  logic [CFG_WIDTH-1:0]     cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  joint_in_t in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  pose_out_t out_data_o;

  arm_forward_kinematics_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [CFG_WIDTH-1:0] link_reg [REVOLUTE_JOINTS];
  pose_out_t expected_poses [$];
  int unsigned mismatch_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;

  // Sine and cosine of a 32-bit turn, Q1.15, by rotation CORDIC.
  function automatic void joint_trig(input logic [31:0] turn, output longint sn,
                                     output longint cs);
    longint x, y, z, dx, dy, lim_hi, lim_lo;
    bit flip;
    flip = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
    if (flip) turn = turn + 32'h8000_0000;
    z = longint'($signed(turn));
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
      end
    end
    x = (x + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    y = (y + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    if (flip) begin
      x = -x; y = -y;
    end
    lim_hi = (longint'(1) << TRIG_FRAC_BITS) - 1;
    lim_lo = -(longint'(1) << TRIG_FRAC_BITS);
    cs = x > lim_hi ? lim_hi : (x < lim_lo ? lim_lo : x);
    sn = y > lim_hi ? lim_hi : (y < lim_lo ? lim_lo : y);
  endfunction

  function automatic logic [OUT_WIDTH-1:0] clamp_pos(input longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[OUT_WIDTH-1:0];
  endfunction

  // Carries the gripper point back through frames 4..0 to the base frame.
  function automatic pose_out_t end_effector(input joint_in_t j);
    logic [ANGLE_WIDTH-1:0] ang [REVOLUTE_JOINTS];
    logic [31:0] turn;
    longint sn, cs, ca, sa, a, d, x, y, z, nx, ny;
    longint half;
    pose_out_t r;
    ang[0] = j.joint_angle_0;
    ang[1] = j.joint_angle_1;
    ang[2] = j.joint_angle_2;
    ang[3] = j.joint_angle_3;
    ang[4] = j.joint_angle_4;
    half = longint'(1) << (TRIG_FRAC_BITS - 1);
    x = 0;
    y = 0;
    z = longint'(link_reg[CFG_GRIPPER]);
    for (int f = REVOLUTE_JOINTS - 1; f >= 0; f--) begin
      turn = {ang[f], 16'h0000};
      if (f == 1) turn = turn + QUARTER_TURN;
      if (f == 3) turn = turn - QUARTER_TURN;
      joint_trig(turn, sn, cs);
      case (FRAME_TWIST[f])
        TWIST_POS: begin ca = 0; sa = 1; end
        TWIST_NEG: begin ca = 0; sa = -1; end
        default:   begin ca = 1; sa = 0; end
      endcase
      a = (f == 1) ? longint'(link_reg[CFG_UPPER_ARM]) :
          (f == 2) ? longint'(link_reg[CFG_FOREARM]) : 0;
      d = (f == 0) ? longint'(link_reg[CFG_BASE]) :
          (f == 4) ? longint'(link_reg[CFG_WRIST]) : 0;
      nx = cs * x - sn * ca * y + sn * sa * z + a * cs;
      ny = sn * x + cs * ca * y - cs * sa * z + a * sn;
      z = sa * y + ca * z + d;
      x = (nx + half) >>> TRIG_FRAC_BITS;
      y = (ny + half) >>> TRIG_FRAC_BITS;
    end
    r.pos_x = clamp_pos(x);
    r.pos_y = clamp_pos(y);
    r.pos_z = clamp_pos(z);
    return r;
  endfunction

  // The write enable stays high between back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx < REVOLUTE_JOINTS) link_reg[idx] = value;
  endtask

  task automatic write_all(input logic [CFG_WIDTH-1:0] v0, v1, v2, v3, v4);
    write_reg(CFG_UPPER_ARM, v0);
    write_reg(CFG_FOREARM, v1);
    write_reg(CFG_BASE, v2);
    write_reg(CFG_WRIST, v3);
    write_reg(CFG_GRIPPER, v4);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_poses.size() != 0) @(posedge clk_i);
  endtask

  // One transaction on the pose channel, with random idle cycles in front.
  task automatic send_pose(input joint_in_t j, input bit typed, input pose_out_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= j;
    do @(posedge clk_i); while (in_stall_o);
    expected_poses.push_back(typed ? want : end_effector(j));
  endtask

  function automatic logic [ANGLE_WIDTH-1:0] rand_angle();
    logic [ANGLE_WIDTH-1:0] base_ang;
    case ($urandom_range(3))
      0: begin
        // Land near a quadrant boundary, where the CORDIC fold changes.
        base_ang = {2'($urandom_range(3)), 14'h0};
        return base_ang + ANGLE_WIDTH'($urandom_range(8)) - ANGLE_WIDTH'(4);
      end
      default: return ANGLE_WIDTH'($urandom());
    endcase
  endfunction

  function automatic joint_in_t mk_pose(input logic [15:0] a0, a1, a2, a3, a4);
    joint_in_t j;
    j.joint_angle_0 = a0;
    j.joint_angle_1 = a1;
    j.joint_angle_2 = a2;
    j.joint_angle_3 = a3;
    j.joint_angle_4 = a4;
    return j;
  endfunction

  function automatic dir_row_t mk_row(input cfg_sel_e sel, input joint_in_t j,
                                      input bit typed);
    dir_row_t r;
    r.cfg_sel = sel;
    r.pose = j;
    r.typed = typed;
    r.want = '0;
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    pose_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_poses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transaction: %h", out_data_o);
      end else begin
        want = expected_poses.pop_front();
        if (out_data_o.pos_x !== want.pos_x || out_data_o.pos_y !== want.pos_y ||
            out_data_o.pos_z !== want.pos_z) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("position mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                     want.pos_x, want.pos_y, want.pos_z,
                     out_data_o.pos_x, out_data_o.pos_y, out_data_o.pos_z);
        end
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    joint_in_t j;
    int unsigned mode;
    link_reg[CFG_UPPER_ARM] = 16'd3891;
    link_reg[CFG_FOREARM]   = 16'd3891;
    link_reg[CFG_BASE]      = 16'd2662;
    link_reg[CFG_WRIST]     = 16'd5325;
    link_reg[CFG_GRIPPER]   = 16'd0;

    // Reset lengths first, then zero lengths, where every pose maps to the
    // origin, then the largest lengths.
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h0, 16'h0, 16'h0, 16'h0, 16'h0), 1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                            16'h7FFF), 1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                            16'h8000), 1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                            16'hFFFF), 1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h4000, 16'h4000, 16'h4000, 16'h4000,
                                            16'h4000), 1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'hC000, 16'hC000, 16'hC000, 16'hC000,
                                            16'hC000), 1'b0));
    // Shoulder and wrist offsets wrap to an effective angle of zero.
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h0, 16'hC000, 16'h0, 16'h4000, 16'h0),
                          1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                            16'h5555), 1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                            16'hAAAA), 1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h2000, 16'hE000, 16'h1000, 16'hF000,
                                            16'h6000), 1'b0));
    rows.push_back(mk_row(CFG_ZERO, mk_pose(16'h0, 16'h0, 16'h0, 16'h0, 16'h0), 1'b1));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                            16'h7FFF), 1'b1));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h1234, 16'hFEDC, 16'h4000, 16'hC000,
                                            16'h8001), 1'b1));
    rows.push_back(mk_row(CFG_MAX, mk_pose(16'h0, 16'h0, 16'h0, 16'h0, 16'h0), 1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                            16'h7FFF), 1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                            16'h8000), 1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'h0, 16'hC000, 16'h0, 16'h4000, 16'h0),
                          1'b0));
    rows.push_back(mk_row(CFG_KEEP, mk_pose(16'hC000, 16'h4000, 16'hC000, 16'h4000,
                                            16'hC000), 1'b0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      if (rows[r].cfg_sel != CFG_KEEP) begin
        in_valid_i <= 1'b0;
        wait_idle();
        if (rows[r].cfg_sel == CFG_ZERO) write_all('0, '0, '0, '0, '0);
        else write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end
      send_pose(rows[r].pose, rows[r].typed, rows[r].want);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      in_valid_i <= 1'b0;
      wait_idle();
      // A write to an unused index must leave every length unchanged.
      write_reg(CFG_IDX_UNUSED, 16'($urandom()));
      case (ph)
        0: write_all(16'd3891, 16'd3891, 16'd2662, 16'd5325, 16'd0);
        3: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: write_all(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           16'($urandom()), 16'($urandom()));
      endcase
      mode = ph % 4;
      sender_idle_pct = (mode == 1) ? 73 : (mode == 3) ? 20 : 0;
      stall_pct       = (mode == 2) ? 73 : (mode == 3) ? 20 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        j = mk_pose(rand_angle(), rand_angle(), rand_angle(), rand_angle(), rand_angle());
        send_pose(j, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_poses.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule
